>>> src/ifc_pkg.sv
// shared types and constants for the imu frame conditioner
package ifc_pkg;

  // sample width of every sensor field and result field
  localparam int DATA_W = 16;

  // lane counts: averaging lanes (accel x/y/z, mag x/y/z) and gyro lanes
  localparam int NUM_AVG  = 6;
  localparam int NUM_GYRO = 3;

  // low-pass coefficient, q0.16
  localparam int ALPHA_W = 16;
  localparam int FRAC_W  = 16;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd7316;
  localparam logic [ALPHA_W:0]   ALPHA_ONE   = 17'h10000;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GYRO_OFF_X = 2'd0,
    CFG_GYRO_OFF_Y = 2'd1,
    CFG_GYRO_OFF_Z = 2'd2,
    CFG_LP_ALPHA   = 2'd3
  } cfg_idx_e;

  // pipeline control shared by all lanes
  typedef struct packed {
    logic adv;         // whole pipeline moves this cycle
    logic a_valid;     // stage a holds a word
    logic b_valid;     // stage b holds a word
    logic a_fwd;       // stage a history slot comes from the word just written
    logic a_slot_vld;  // stage a history slot was written since reset
  } lane_ctrl_t;

endpackage

>>> src/ifc_ram.sv
// generic single-write, single-read ram with registered read data
module ifc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 100
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ifc_avg_lane.sv
// one moving-average lane: history ram, running sum and divide by the window
module ifc_avg_lane #(
  parameter int WINDOW_LENGTH = 100
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  ifc_pkg::lane_ctrl_t                    ctrl_i,
  input  logic [((WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1)-1:0] rd_pos_i,
  input  logic [((WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1)-1:0] wr_pos_i,
  input  logic signed [ifc_pkg::DATA_W-1:0]      x_i,
  output logic signed [ifc_pkg::DATA_W-1:0]      avg_o
);

  import ifc_pkg::*;

  localparam int LOG_W   = $clog2(WINDOW_LENGTH);
  localparam int SUM_W   = DATA_W + LOG_W;
  localparam int MAG_W   = SUM_W;
  localparam int SHIFT   = MAG_W + LOG_W;
  localparam int RECIP_W = MAG_W + 1;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam int QUOT_W  = DATA_W + 1;
  // ceil(2^SHIFT / window) gives an exact floor quotient for any magnitude
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  logic signed [DATA_W-1:0] x_a_q;
  logic signed [DATA_W-1:0] fwd_x_q;
  logic        [DATA_W-1:0] rd_data;
  logic signed [DATA_W-1:0] old_x;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [SUM_W-1:0]  sum_d;
  logic        [MAG_W-1:0]  mag;
  logic        [PROD_W-1:0] prod_c_q;
  logic                     neg_c_q;
  logic        [QUOT_W-1:0] quot;
  logic        [QUOT_W-1:0] res;

  // sample history ring
  ifc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(WINDOW_LENGTH)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.adv && ctrl_i.a_valid),
    .waddr_i(wr_pos_i),
    .wdata_i(x_a_q),
    .re_i   (ctrl_i.adv),
    .raddr_i(rd_pos_i),
    .rdata_o(rd_data)
  );

  // oldest sample: forwarded, from the ring, or zero for a slot never written
  always_comb begin
    if (ctrl_i.a_fwd) begin
      old_x = fwd_x_q;
    end else if (ctrl_i.a_slot_vld) begin
      old_x = rd_data;
    end else begin
      old_x = '0;
    end
    sum_d = sum_q + SUM_W'(x_a_q) - SUM_W'(old_x);
  end

  // running sum, updated as a word leaves stage a
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.adv && ctrl_i.a_valid) begin
      sum_q <= sum_d;
    end
  end

  // magnitude of the sum for the reciprocal multiply
  assign mag = sum_q[SUM_W-1] ? MAG_W'(-sum_q) : MAG_W'(sum_q);

  // stage registers: input sample, forward copy, product
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      x_a_q    <= x_i;
      fwd_x_q  <= x_a_q;
      neg_c_q  <= sum_q[SUM_W-1];
      prod_c_q <= PROD_W'(mag) * PROD_W'(RECIP);
    end
  end

  // quotient with sign restored, truncated toward zero
  assign quot  = prod_c_q[SHIFT +: QUOT_W];
  assign res   = neg_c_q ? (-quot) : quot;
  assign avg_o = res[DATA_W-1:0];

endmodule

>>> src/ifc_gyro_lane.sv
// one gyro lane: offset removal and first-order low-pass
module ifc_gyro_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ifc_pkg::lane_ctrl_t               ctrl_i,
  input  logic signed [ifc_pkg::DATA_W-1:0] offset_i,
  input  logic [ifc_pkg::ALPHA_W-1:0]       alpha_i,
  input  logic signed [ifc_pkg::DATA_W-1:0] g_i,
  output logic signed [ifc_pkg::DATA_W-1:0] smooth_o
);

  import ifc_pkg::*;

  localparam int AX_W  = DATA_W + ALPHA_W + 1;
  localparam int NUM_W = AX_W + 1;
  localparam int Y_W   = NUM_W - FRAC_W;

  logic signed [DATA_W-1:0] g_a_q;
  logic signed [DATA_W-1:0] x_corr;
  logic signed [AX_W-1:0]   ax;
  logic signed [AX_W-1:0]   ax_b_q;
  logic        [ALPHA_W:0]  beta;
  logic signed [NUM_W-1:0]  prod;
  logic signed [NUM_W-1:0]  num;
  logic signed [Y_W-1:0]    y_floor;
  logic signed [Y_W-1:0]    y_trunc;
  logic signed [DATA_W-1:0] y;
  logic signed [DATA_W-1:0] prev_q;
  logic signed [DATA_W-1:0] y_c_q;

  // stage a: offset removal wraps to 16 bits, then alpha * x
  assign x_corr = g_a_q - offset_i;
  assign ax     = $signed({1'b0, alpha_i}) * x_corr;

  // stage b: y = (prev * (1 - alpha) + alpha * x) / 2^16, toward zero
  assign beta    = ALPHA_ONE - {1'b0, alpha_i};
  assign prod    = prev_q * $signed({1'b0, beta});
  assign num     = prod + NUM_W'(ax_b_q);
  assign y_floor = num[NUM_W-1:FRAC_W];
  assign y_trunc = (num[NUM_W-1] && (|num[FRAC_W-1:0])) ? (y_floor + Y_W'(1)) : y_floor;
  assign y       = y_trunc[DATA_W-1:0];

  // filter state, updated as a word leaves stage b
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (ctrl_i.adv && ctrl_i.b_valid) begin
      prev_q <= y;
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      g_a_q  <= g_i;
      ax_b_q <= ax;
      y_c_q  <= y;
    end
  end

  assign smooth_o = y_c_q;

endmodule

>>> src/ifc_merge.sv
// merging stage: collects the lane results into the output register
module ifc_merge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              c_valid_i,
  input  logic signed [ifc_pkg::DATA_W-1:0] avg_i  [ifc_pkg::NUM_AVG],
  input  logic signed [ifc_pkg::DATA_W-1:0] gyro_i [ifc_pkg::NUM_GYRO],
  input  logic                              out_ready_i,
  output logic                              adv_o,
  output logic                              out_valid_o,
  output logic signed [ifc_pkg::DATA_W-1:0] avg_o  [ifc_pkg::NUM_AVG],
  output logic signed [ifc_pkg::DATA_W-1:0] gyro_o [ifc_pkg::NUM_GYRO]
);

  import ifc_pkg::*;

  logic                     out_valid_q;
  logic signed [DATA_W-1:0] avg_q  [NUM_AVG];
  logic signed [DATA_W-1:0] gyro_q [NUM_GYRO];

  // pipeline moves whenever the output register is empty or being drained
  assign adv_o = !out_valid_q || out_ready_i;

  // output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= c_valid_i;
    end
  end

  // output word payload
  always_ff @(posedge clk_i) begin
    if (adv_o && c_valid_i) begin
      avg_q  <= avg_i;
      gyro_q <= gyro_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign avg_o       = avg_q;
  assign gyro_o      = gyro_q;

endmodule

>>> src/imu_frame_conditioner.sv
// top level of the imu frame conditioner
//
// Usage: one nine-axis frame enters as a word on the input channel
// (in_valid_i / in_ready_o); one conditioned word leaves on the output
// channel (out_valid_o / out_ready_i). Accel and mag channels come out as
// a moving average over WINDOW_LENGTH frames, gyro channels as an
// offset-corrected first-order low-pass. Nine lanes work side by side,
// each lane owning its own history ram or filter state.
// Path to out_valid_o: stage a loads at the accepting edge, then stages b,
// c and the output register follow. Throughput: one frame per cycle while
// the receiver does not stall, set by the low-pass recurrence through
// prev_q alone and the single read and write port of each history ram.
// Reset clears the running sums, the ring position and the gyro state;
// history slots carry a valid bit each, cleared at once, so no clearing
// pass is needed and frames are taken right after reset.
// When the receiver stalls, the output register holds its word and the
// whole pipeline freezes; in_ready_o drops only while a word waits there.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once;
// the user must make them while the block is idle; the block does not enforce it.
module imu_frame_conditioner #(
  parameter int WINDOW_LENGTH = 100
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [ifc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ifc_pkg::DATA_W-1:0]         cfg_data_i,
  // input frame
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [ifc_pkg::DATA_W-1:0]  accel_x_in_i,
  input  logic signed [ifc_pkg::DATA_W-1:0]  accel_y_in_i,
  input  logic signed [ifc_pkg::DATA_W-1:0]  accel_z_in_i,
  input  logic signed [ifc_pkg::DATA_W-1:0]  gyro_x_in_i,
  input  logic signed [ifc_pkg::DATA_W-1:0]  gyro_y_in_i,
  input  logic signed [ifc_pkg::DATA_W-1:0]  gyro_z_in_i,
  input  logic signed [ifc_pkg::DATA_W-1:0]  mag_x_in_i,
  input  logic signed [ifc_pkg::DATA_W-1:0]  mag_y_in_i,
  input  logic signed [ifc_pkg::DATA_W-1:0]  mag_z_in_i,
  // output frame
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [ifc_pkg::DATA_W-1:0]  accel_x_avg_o,
  output logic signed [ifc_pkg::DATA_W-1:0]  accel_y_avg_o,
  output logic signed [ifc_pkg::DATA_W-1:0]  accel_z_avg_o,
  output logic signed [ifc_pkg::DATA_W-1:0]  mag_x_avg_o,
  output logic signed [ifc_pkg::DATA_W-1:0]  mag_y_avg_o,
  output logic signed [ifc_pkg::DATA_W-1:0]  mag_z_avg_o,
  output logic signed [ifc_pkg::DATA_W-1:0]  gyro_x_smooth_o,
  output logic signed [ifc_pkg::DATA_W-1:0]  gyro_y_smooth_o,
  output logic signed [ifc_pkg::DATA_W-1:0]  gyro_z_smooth_o
);

  import ifc_pkg::*;

  localparam int POS_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LENGTH - 1);

  logic                     adv;
  logic                     accept;
  logic                     valid_a_q;
  logic                     valid_b_q;
  logic                     valid_c_q;
  logic [POS_W-1:0]         pos_q;
  logic [POS_W-1:0]         pos_d;
  logic [POS_W-1:0]         pos_a_q;
  logic [WINDOW_LENGTH-1:0] slot_vld_q;
  logic                     slot_vld_a_q;
  logic                     fwd_a_q;
  lane_ctrl_t               ctrl;

  logic signed [DATA_W-1:0] gyro_off_q [NUM_GYRO];
  logic [ALPHA_W-1:0]       alpha_q;

  logic signed [DATA_W-1:0] avg_in    [NUM_AVG];
  logic signed [DATA_W-1:0] gyro_in   [NUM_GYRO];
  logic signed [DATA_W-1:0] avg_res   [NUM_AVG];
  logic signed [DATA_W-1:0] gyro_res  [NUM_GYRO];
  logic signed [DATA_W-1:0] avg_out   [NUM_AVG];
  logic signed [DATA_W-1:0] gyro_out  [NUM_GYRO];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_off_q <= '{default: '0};
      alpha_q    <= ALPHA_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GYRO_OFF_X: gyro_off_q[0] <= cfg_data_i;
        CFG_GYRO_OFF_Y: gyro_off_q[1] <= cfg_data_i;
        CFG_GYRO_OFF_Z: gyro_off_q[2] <= cfg_data_i;
        CFG_LP_ALPHA:   alpha_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input handshake and ring position
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;
  assign pos_d      = (pos_q == POS_LAST) ? '0 : (pos_q + POS_W'(1));

  // pipeline control: stage valids, ring pointer, history slot valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q  <= 1'b0;
      valid_b_q  <= 1'b0;
      valid_c_q  <= 1'b0;
      pos_q      <= '0;
      slot_vld_q <= '0;
    end else if (adv) begin
      valid_a_q <= in_valid_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
      if (in_valid_i) begin
        pos_q <= pos_d;
      end
      if (valid_a_q) begin
        slot_vld_q[pos_a_q] <= 1'b1;
      end
    end
  end

  // stage a slot info, captured with the word
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_a_q      <= pos_q;
      slot_vld_a_q <= slot_vld_q[pos_q];
      fwd_a_q      <= valid_a_q && (pos_a_q == pos_q);
    end
  end

  always_comb begin
    ctrl            = '0;
    ctrl.adv        = adv;
    ctrl.a_valid    = valid_a_q;
    ctrl.b_valid    = valid_b_q;
    ctrl.a_fwd      = fwd_a_q;
    ctrl.a_slot_vld = slot_vld_a_q;
  end

  // lane inputs
  assign avg_in[0]  = accel_x_in_i;
  assign avg_in[1]  = accel_y_in_i;
  assign avg_in[2]  = accel_z_in_i;
  assign avg_in[3]  = mag_x_in_i;
  assign avg_in[4]  = mag_y_in_i;
  assign avg_in[5]  = mag_z_in_i;
  assign gyro_in[0] = gyro_x_in_i;
  assign gyro_in[1] = gyro_y_in_i;
  assign gyro_in[2] = gyro_z_in_i;

  // averaging lanes
  for (genvar k = 0; k < NUM_AVG; k++) begin : g_avg
    ifc_avg_lane #(
      .WINDOW_LENGTH(WINDOW_LENGTH)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .rd_pos_i(pos_q),
      .wr_pos_i(pos_a_q),
      .x_i     (avg_in[k]),
      .avg_o   (avg_res[k])
    );
  end

  // gyro lanes
  for (genvar k = 0; k < NUM_GYRO; k++) begin : g_gyro
    ifc_gyro_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .offset_i(gyro_off_q[k]),
      .alpha_i (alpha_q),
      .g_i     (gyro_in[k]),
      .smooth_o(gyro_res[k])
    );
  end

  // merge into the output register
  ifc_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .c_valid_i  (valid_c_q),
    .avg_i      (avg_res),
    .gyro_i     (gyro_res),
    .out_ready_i(out_ready_i),
    .adv_o      (adv),
    .out_valid_o(out_valid_o),
    .avg_o      (avg_out),
    .gyro_o     (gyro_out)
  );

  assign accel_x_avg_o   = avg_out[0];
  assign accel_y_avg_o   = avg_out[1];
  assign accel_z_avg_o   = avg_out[2];
  assign mag_x_avg_o     = avg_out[3];
  assign mag_y_avg_o     = avg_out[4];
  assign mag_z_avg_o     = avg_out[5];
  assign gyro_x_smooth_o = gyro_out[0];
  assign gyro_y_smooth_o = gyro_out[1];
  assign gyro_z_smooth_o = gyro_out[2];

endmodule

>>> src/ifc_checker.sv
// port-level checks for the imu frame conditioner, bound to the top level
module ifc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [ifc_pkg::DATA_W-1:0] accel_x_avg_o,
  input logic signed [ifc_pkg::DATA_W-1:0] gyro_x_smooth_o
);

  // a waiting word that is not taken backpressures the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input ready while output word stalls");

  // an empty output register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output register");

  // a stalled word stays and holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(accel_x_avg_o) && $stable(gyro_x_smooth_o)))
    else $error("stalled output word changed");

  // output valid drops only after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("output word dropped without transfer");

endmodule

bind imu_frame_conditioner ifc_checker u_ifc_checker (.*);
